[sv/ctt_pkg.sv]
// Shared types, token kind codes and character classes of the configuration text tokenizer.
// No dependencies; every other file of the block but ctt_char_if imports this package.
package ctt_pkg;

  // Width of the offset and length fields of a token.
  localparam int TokenW = 12;

  // Depth of the token queue between the scanner and the output port.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // Token kind codes.
  localparam logic [3:0] KIND_END     = 4'd0;
  localparam logic [3:0] KIND_LPAREN  = 4'd1;
  localparam logic [3:0] KIND_RPAREN  = 4'd2;
  localparam logic [3:0] KIND_SEMI    = 4'd3;
  localparam logic [3:0] KIND_COLON   = 4'd4;
  localparam logic [3:0] KIND_COMMA   = 4'd5;
  localparam logic [3:0] KIND_STAR    = 4'd6;
  localparam logic [3:0] KIND_LBRACK  = 4'd7;
  localparam logic [3:0] KIND_RBRACK  = 4'd8;
  localparam logic [3:0] KIND_LBRACE  = 4'd9;
  localparam logic [3:0] KIND_RBRACE  = 4'd10;
  localparam logic [3:0] KIND_EQUALS  = 4'd11;
  localparam logic [3:0] KIND_STRING  = 4'd12;
  localparam logic [3:0] KIND_IDENT   = 4'd13;
  localparam logic [3:0] KIND_NUMBER  = 4'd14;
  localparam logic [3:0] KIND_UNKNOWN = 4'd15;

  // Characters with a role of their own in the scanner.
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_UNDERLINE = 8'h5F;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;

  // One token as it leaves the block.
  typedef struct packed {
    logic [3:0]        kind;
    logic [TokenW-1:0] start;
    logic [TokenW-1:0] length;
    logic              last;
  } token_t;

  // Tokens produced by the scanner for one byte, pushed into the queue together.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } scan_push_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
               (c == 8'h0B) || (c == 8'h0C);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Kind of a single-character punctuation token, or KIND_END if the byte is none.
  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    case (c)
      8'h28:   punct_kind = KIND_LPAREN;
      8'h29:   punct_kind = KIND_RPAREN;
      8'h3B:   punct_kind = KIND_SEMI;
      8'h3A:   punct_kind = KIND_COLON;
      8'h2C:   punct_kind = KIND_COMMA;
      8'h2A:   punct_kind = KIND_STAR;
      8'h5B:   punct_kind = KIND_LBRACK;
      8'h5D:   punct_kind = KIND_RBRACK;
      8'h7B:   punct_kind = KIND_LBRACE;
      8'h7D:   punct_kind = KIND_RBRACE;
      8'h3D:   punct_kind = KIND_EQUALS;
      default: punct_kind = KIND_END;
    endcase
  endfunction

endpackage

[sv/ctt_char_if.sv]
// Valid/ready channel that carries one byte of configuration text per word.
// No dependencies.
interface ctt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

[sv/ctt_token_if.sv]
// Valid/ready channel that carries one token per word.
// Depends on ctt_pkg for the field widths.
interface ctt_token_if import ctt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [3:0]        token_kind;
  logic [TokenW-1:0] token_start;
  logic [TokenW-1:0] token_length;
  logic              last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

[sv/config_text_tokenizer_core.sv]
// Top level of the configuration text tokenizer: byte scanner feeding a token queue.
// Depends on ctt_pkg, ctt_char_if, ctt_token_if, ctt_scanner and ctt_token_queue.
//
// Takes one byte of text per word on in_i (a zero byte ends the stream) and returns tokens on
// out_o as kind, start offset, length and a flag on the last token caused by each byte.
// Whitespace and line and block comments are skipped. A byte is taken every cycle while the token
// queue has room for two tokens; a byte is held in the input register and its tokens in the
// token queue. A byte can close one token and start or finish another, so it may yield two
// tokens; the output then drains one token a cycle while out_o is ready, through a four-entry
// queue, and input is held off only while that queue has fewer than two free entries. Offsets
// count modulo BUFFER_BYTES and restart at zero after each end token.
module config_text_tokenizer_core import ctt_pkg::*; #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctt_char_if.sink    in_i,
  ctt_token_if.source out_o
);

  scan_push_t push;
  logic       space_ok;

  // Byte scanner with its state machine.
  ctt_scanner #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_scanner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  // Token queue towards the output port.
  ctt_token_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .out_o      (out_o)
  );

endmodule

[sv/ctt_scanner.sv]
// Byte register and scanner state machine: classifies each byte and produces up to two tokens.
// Depends on ctt_pkg and ctt_char_if.
module ctt_scanner import ctt_pkg::*; #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctt_char_if.sink   in_i,
  input  logic       space_ok_i,
  output scan_push_t push_o
);

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam logic [PW:0]   BufLen  = (PW + 1)'(BUFFER_BYTES);
  localparam logic [PW-1:0] LastPos = PW'(BUFFER_BYTES - 1);

  // Scanner states.
  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_SLASH = 4'd1;
  localparam logic [3:0] M_LINE  = 4'd2;
  localparam logic [3:0] M_BLOCK = 4'd3;
  localparam logic [3:0] M_BSTAR = 4'd4;
  localparam logic [3:0] M_STR   = 4'd5;
  localparam logic [3:0] M_ESC   = 4'd6;
  localparam logic [3:0] M_IDENT = 4'd7;
  localparam logic [3:0] M_NUM   = 4'd8;
  localparam logic [3:0] M_MINUS = 4'd9;

  logic          cvalid_q;
  logic [7:0]    char_q;
  logic [3:0]    mode_q, mode_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] pend_q, pend_d;
  logic          fire;

  // The held byte is processed once the queue has room for two tokens.
  assign fire     = cvalid_q && space_ok_i;
  assign in_i.ready = !cvalid_q || fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvalid_q <= 1'b0;
    end else if (in_i.ready) begin
      cvalid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.char_in;
    end
  end

  // Offsets modulo the buffer size, widened to the token field width.
  logic [PW-1:0]        pos_inc;
  logic [PW:0]          diff;
  logic [PW:0]          span_full;
  logic [PW+TokenW-1:0] pos_ext, pend_ext, span_ext;
  logic [TokenW-1:0]    pos12, pend12, span12;

  assign pos_inc   = (pos_q == LastPos) ? '0 : pos_q + 1'b1;
  assign diff      = {1'b0, pos_q} - {1'b0, pend_q};
  assign span_full = diff[PW] ? diff + BufLen : diff;
  assign pos_ext   = {{TokenW{1'b0}}, pos_q};
  assign pend_ext  = {{TokenW{1'b0}}, pend_q};
  assign span_ext  = {{TokenW{1'b0}}, span_full[PW-1:0]};
  assign pos12     = pos_ext[TokenW-1:0];
  assign pend12    = pend_ext[TokenW-1:0];
  assign span12    = span_ext[TokenW-1:0];

  // Handling of a byte that arrives between tokens.
  logic              idle_emit;
  logic [3:0]        idle_kind;
  logic              idle_len;
  logic [3:0]        idle_mode;
  logic              idle_set;
  logic [TokenW-1:0] idle_start;
  logic [PW-1:0]     idle_pend;
  logic              idle_end;
  logic [3:0]        pk;

  always_comb begin
    pk         = punct_kind(char_q);
    idle_emit  = 1'b0;
    idle_kind  = KIND_END;
    idle_len   = 1'b0;
    idle_mode  = M_IDLE;
    idle_set   = 1'b0;
    idle_start = pos12;
    idle_pend  = pos_q;
    idle_end   = 1'b0;
    if (char_q == CH_NUL) begin
      idle_emit = 1'b1;
      idle_end  = 1'b1;
    end else if (is_space(char_q)) begin
      idle_emit = 1'b0;
    end else if (pk != KIND_END) begin
      idle_emit = 1'b1;
      idle_kind = pk;
      idle_len  = 1'b1;
    end else if (char_q == CH_SLASH) begin
      idle_mode = M_SLASH;
      idle_set  = 1'b1;
    end else if (char_q == CH_QUOTE) begin
      idle_mode = M_STR;
      idle_set  = 1'b1;
      idle_pend = pos_inc;
    end else if (is_letter(char_q)) begin
      idle_mode = M_IDENT;
      idle_set  = 1'b1;
    end else if (is_digit(char_q)) begin
      idle_mode = M_NUM;
      idle_set  = 1'b1;
    end else if (char_q == CH_MINUS) begin
      idle_mode = M_MINUS;
      idle_set  = 1'b1;
    end else begin
      idle_emit = 1'b1;
      idle_kind = KIND_UNKNOWN;
      idle_len  = 1'b1;
    end
  end

  // Scanner state machine: closes a pending token and decides whether the byte
  // is then scanned as if between tokens.
  logic              pre_emit;
  logic [3:0]        pre_kind;
  logic [TokenW-1:0] pre_len;
  logic              use_idle;
  logic              ended;
  logic              ident_char;

  always_comb begin
    ident_char = is_letter(char_q) || is_digit(char_q) || (char_q == CH_UNDERLINE);
    pre_emit   = 1'b0;
    pre_kind   = KIND_UNKNOWN;
    pre_len    = span12;
    use_idle   = 1'b0;
    mode_d     = mode_q;
    unique case (mode_q) inside
      M_SLASH: begin
        if (char_q == CH_SLASH) begin
          mode_d = M_LINE;
        end else if (char_q == CH_STAR) begin
          mode_d = M_BLOCK;
        end else begin
          pre_emit = 1'b1;
          pre_len  = TokenW'(1);
          use_idle = 1'b1;
        end
      end
      M_LINE: begin
        if (char_q == CH_NUL) begin
          use_idle = 1'b1;
        end else if ((char_q == CH_LF) || (char_q == CH_CR)) begin
          mode_d = M_IDLE;
        end
      end
      M_BLOCK, M_BSTAR: begin
        if (char_q == CH_NUL) begin
          use_idle = 1'b1;
        end else if ((mode_q == M_BSTAR) && (char_q == CH_SLASH)) begin
          mode_d = M_IDLE;
        end else begin
          mode_d = (char_q == CH_STAR) ? M_BSTAR : M_BLOCK;
        end
      end
      M_STR: begin
        pre_kind = KIND_STRING;
        if (char_q == CH_NUL) begin
          pre_emit = 1'b1;
          use_idle = 1'b1;
        end else if (char_q == CH_QUOTE) begin
          pre_emit = 1'b1;
          mode_d   = M_IDLE;
        end else if (char_q == CH_BACKSLASH) begin
          mode_d = M_ESC;
        end
      end
      M_ESC: begin
        pre_kind = KIND_STRING;
        if (char_q == CH_NUL) begin
          pre_emit = 1'b1;
          use_idle = 1'b1;
        end else begin
          mode_d = M_STR;
        end
      end
      M_IDENT: begin
        pre_kind = KIND_IDENT;
        if (!ident_char) begin
          pre_emit = 1'b1;
          use_idle = 1'b1;
        end
      end
      M_NUM: begin
        pre_kind = KIND_NUMBER;
        if (!(is_digit(char_q) || (char_q == CH_DOT))) begin
          pre_emit = 1'b1;
          use_idle = 1'b1;
        end
      end
      M_MINUS: begin
        if (is_digit(char_q)) begin
          mode_d = M_NUM;
        end else begin
          pre_emit = 1'b1;
          pre_len  = TokenW'(1);
          use_idle = 1'b1;
        end
      end
      default: begin
        use_idle = 1'b1;
      end
    endcase

    ended  = use_idle && idle_end;
    pend_d = pend_q;
    if (use_idle) begin
      mode_d = idle_mode;
      if (idle_set) begin
        pend_d = idle_pend;
      end
    end
    pos_d = pos_inc;
    if (ended) begin
      mode_d = M_IDLE;
      pos_d  = '0;
      pend_d = '0;
    end
  end

  // Tokens for this byte, the last one flagged.
  logic   second;
  token_t idle_tok;

  always_comb begin
    idle_tok.kind   = idle_kind;
    idle_tok.start  = idle_start;
    idle_tok.length = {{(TokenW-1){1'b0}}, idle_len};
    idle_tok.last   = 1'b1;
    second          = use_idle && idle_emit;
    push_o.tok1     = idle_tok;
    if (pre_emit) begin
      push_o.tok0.kind   = pre_kind;
      push_o.tok0.start  = pend12;
      push_o.tok0.length = pre_len;
      push_o.tok0.last   = !second;
    end else begin
      push_o.tok0 = idle_tok;
    end
    if (!fire) begin
      push_o.count = 2'd0;
    end else if (pre_emit && second) begin
      push_o.count = 2'd2;
    end else if (pre_emit || second) begin
      push_o.count = 2'd1;
    end else begin
      push_o.count = 2'd0;
    end
  end

  // Scanner state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pos_q  <= '0;
      pend_q <= '0;
    end else if (fire) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      pend_q <= pend_d;
    end
  end

  // A zero byte always restarts the offsets of the next stream at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (char_q == CH_NUL)) |=> ((pos_q == '0) && (mode_q == M_IDLE)))
    else $error("offset not restarted after end of stream");

  // The end of stream always yields an end word as the last token of the byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (char_q == CH_NUL)) |->
      ((push_o.count != 2'd0) &&
       (((push_o.count == 2'd1) && (push_o.tok0.kind == KIND_END)) ||
        ((push_o.count == 2'd2) && (push_o.tok1.kind == KIND_END)))))
    else $error("end of stream without end token");

endmodule

[sv/ctt_token_queue.sv]
// Small token queue between the scanner and the output port; takes up to two words a cycle.
// Depends on ctt_pkg and ctt_token_if.
module ctt_token_queue import ctt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  scan_push_t   push_i,
  output logic         space_ok_o,
  ctt_token_if.source  out_o
);

  token_t                 entry_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]     count_q;
  logic                   pop;
  logic [QueuePtrW-1:0]   wr_ptr_nx;
  token_t                 head;

  assign pop        = out_o.valid && out_o.ready;
  assign space_ok_o = count_q <= (QueuePtrW + 1)'(QueueDepth - 2);
  assign wr_ptr_nx  = wr_ptr_q + 1'b1;

  // Output port shows the head entry.
  assign head               = entry_q[rd_ptr_q];
  assign out_o.valid        = count_q != '0;
  assign out_o.token_kind   = head.kind;
  assign out_o.token_start  = head.start;
  assign out_o.token_length = head.length;
  assign out_o.last_of_run  = head.last;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.tok0;
    end
    if (push_i.count == 2'd2) begin
      entry_q[wr_ptr_nx] <= push_i.tok1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QueuePtrW'(push_i.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (QueuePtrW + 1)'(push_i.count) - (QueuePtrW + 1)'(pop);
    end
  end

  // Pushes never overrun the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_q} + (QueuePtrW + 2)'(push_i.count)) <= (QueuePtrW + 2)'(QueueDepth))
    else $error("token queue overrun");

  // Fill count tracks the pointer distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != (QueuePtrW + 1)'(QueueDepth)) |->
      (QueuePtrW'(wr_ptr_q - rd_ptr_q) == count_q[QueuePtrW-1:0]))
    else $error("token queue count and pointers disagree");

endmodule

[tb/config_text_tokenizer_core_test.sv]
// Testbench for config_text_tokenizer_core: streams of configuration text go in a word at a
// time, and every token that comes back is checked against a scanner model kept in this file.
// Depends on ctt_pkg, ctt_char_if, ctt_token_if and the tokenizer RTL.
module config_text_tokenizer_core_test;
  import ctt_pkg::*;

  localparam int BufBytes    = 4096;
  localparam int RandomBytes = 1420;
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 8;
  localparam int MaxWait     = 14;

  // Character sets used to build text.
  localparam string Letters   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string Digits    = "0123456789";
  localparam string WordChars = "abcxyzABCXYZ_0189";
  localparam string NumChars  = "0123456789..";
  localparam string Puncts    = "(){}[]:;,*=";
  localparam string Blanks    = " \011\012\013\014\015";
  localparam string Unknowns  = "@#$%&!?<>|~`'+._\\";

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_SLASH, SCAN_LINE, SCAN_BLOCK, SCAN_BSTAR,
    SCAN_STRING, SCAN_ESCAPE, SCAN_IDENT, SCAN_NUMBER, SCAN_MINUS
  } scan_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  ctt_char_if  text_ch ();
  ctt_token_if tok_ch ();

  config_text_tokenizer_core #(.BUFFER_BYTES(BufBytes)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_ch.sink),
    .out_o  (tok_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scanner model state and the tokens it still expects from the block.
  scan_e       scan_st = SCAN_IDLE;
  logic [11:0] byte_pos = '0;
  logic [11:0] tok_start = '0;
  int          byte_toks;
  token_t      tokens_due[$];

  // Text waiting to be sent, and bookkeeping.
  logic [7:0]  text_bytes[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          bytes_taken = 0;
  int          tokens_taken = 0;
  int          gap_left = 0;
  int          stall_left = 0;

  always @(posedge clk_i) cycles++;

  function automatic bit blank_ch(logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  function automatic bit alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit num_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [3:0] punct_of(logic [7:0] c);
    case (c)
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      ";":     return KIND_SEMI;
      ":":     return KIND_COLON;
      ",":     return KIND_COMMA;
      "*":     return KIND_STAR;
      "[":     return KIND_LBRACK;
      "]":     return KIND_RBRACK;
      "{":     return KIND_LBRACE;
      "}":     return KIND_RBRACE;
      "=":     return KIND_EQUALS;
      default: return KIND_END;
    endcase
  endfunction

  function automatic void push_token(logic [3:0] kind, logic [11:0] start, logic [11:0] len);
    if (byte_toks < 2) begin
      tokens_due.push_back('{kind: kind, start: start, length: len, last: 1'b0});
      byte_toks++;
    end
  endfunction

  // Handles a byte with no token in progress; returns 1 when the byte ends the stream.
  function automatic bit begin_token(logic [7:0] c, logic [11:0] pos);
    logic [3:0] k;
    k = punct_of(c);
    scan_st = SCAN_IDLE;
    if (c == CH_NUL) begin
      push_token(KIND_END, pos, 12'd0);
      return 1'b1;
    end
    if (blank_ch(c)) return 1'b0;
    if (k != KIND_END) begin
      push_token(k, pos, 12'd1);
    end else if (c == CH_SLASH) begin
      scan_st = SCAN_SLASH;
      tok_start = pos;
    end else if (c == CH_QUOTE) begin
      scan_st = SCAN_STRING;
      tok_start = pos + 12'd1;
    end else if (alpha_ch(c)) begin
      scan_st = SCAN_IDENT;
      tok_start = pos;
    end else if (num_ch(c)) begin
      scan_st = SCAN_NUMBER;
      tok_start = pos;
    end else if (c == CH_MINUS) begin
      scan_st = SCAN_MINUS;
      tok_start = pos;
    end else begin
      push_token(KIND_UNKNOWN, pos, 12'd1);
    end
    return 1'b0;
  endfunction

  // Advances the scanner model by one byte and queues the tokens that byte completes.
  // Offsets are 12 bits wide, so they wrap at the buffer size on their own.
  task automatic tokenize_byte(input logic [7:0] c);
    logic [11:0] pos;
    bit          ended;
    token_t      tail;
    pos = byte_pos;
    ended = 1'b0;
    byte_toks = 0;
    case (scan_st)
      SCAN_SLASH: begin
        if (c == CH_SLASH) begin
          scan_st = SCAN_LINE;
        end else if (c == CH_STAR) begin
          scan_st = SCAN_BLOCK;
        end else begin
          push_token(KIND_UNKNOWN, tok_start, 12'd1);
          ended = begin_token(c, pos);
        end
      end
      SCAN_LINE: begin
        if (c == CH_NUL) ended = begin_token(c, pos);
        else if (c == CH_LF || c == CH_CR) scan_st = SCAN_IDLE;
      end
      SCAN_BLOCK, SCAN_BSTAR: begin
        if (c == CH_NUL) ended = begin_token(c, pos);
        else if (scan_st == SCAN_BSTAR && c == CH_SLASH) scan_st = SCAN_IDLE;
        else scan_st = (c == CH_STAR) ? SCAN_BSTAR : SCAN_BLOCK;
      end
      SCAN_STRING: begin
        if (c == CH_NUL) begin
          push_token(KIND_STRING, tok_start, pos - tok_start);
          ended = begin_token(c, pos);
        end else if (c == CH_QUOTE) begin
          push_token(KIND_STRING, tok_start, pos - tok_start);
          scan_st = SCAN_IDLE;
        end else if (c == CH_BACKSLASH) begin
          scan_st = SCAN_ESCAPE;
        end
      end
      SCAN_ESCAPE: begin
        if (c == CH_NUL) begin
          push_token(KIND_STRING, tok_start, pos - tok_start);
          ended = begin_token(c, pos);
        end else begin
          scan_st = SCAN_STRING;
        end
      end
      SCAN_IDENT: begin
        if (!(alpha_ch(c) || num_ch(c) || c == CH_UNDERLINE)) begin
          push_token(KIND_IDENT, tok_start, pos - tok_start);
          ended = begin_token(c, pos);
        end
      end
      SCAN_NUMBER: begin
        if (!(num_ch(c) || c == CH_DOT)) begin
          push_token(KIND_NUMBER, tok_start, pos - tok_start);
          ended = begin_token(c, pos);
        end
      end
      SCAN_MINUS: begin
        if (num_ch(c)) begin
          scan_st = SCAN_NUMBER;
        end else begin
          push_token(KIND_UNKNOWN, tok_start, 12'd1);
          ended = begin_token(c, pos);
        end
      end
      default: ended = begin_token(c, pos);
    endcase

    // The last token caused by this byte carries the flag.
    if (byte_toks > 0) begin
      tail = tokens_due.pop_back();
      tail.last = 1'b1;
      tokens_due.push_back(tail);
    end

    if (ended) begin
      scan_st = SCAN_IDLE;
      byte_pos = '0;
      tok_start = '0;
    end else begin
      byte_pos = pos + 12'd1;
    end
  endtask

  // Text building.
  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic put(input logic [7:0] c);
    text_bytes.push_back(c);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // String contents without the quotes; escapes may be followed by any non-zero byte.
  task automatic add_string_body(input int n);
    logic [7:0] c;
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) begin
        put(CH_BACKSLASH);
        put(any_byte());
      end else begin
        c = any_byte();
        put((c == CH_QUOTE || c == CH_BACKSLASH) ? 8'h61 : c);
      end
    end
  endtask

  // One stream: mostly well-formed tokens with random content, sometimes pure noise,
  // finished by an optional open construct and the zero byte.
  task automatic add_stream();
    int         n;
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) put(any_byte());
    end else begin
      repeat ($urandom_range(1, 10)) begin
        n = $urandom_range(0, 6);
        case ($urandom_range(0, 15))
          0, 14: repeat (n / 2 + 1) put(pick(Blanks));
          1, 13: put(pick(Puncts));
          2, 15: begin
            put(pick(Letters));
            repeat (n) put(pick(WordChars));
          end
          3: begin
            if ($urandom_range(0, 1) == 1) put(CH_MINUS);
            put(pick(Digits));
            repeat (n) put(pick(NumChars));
          end
          4, 5: begin
            put(CH_QUOTE);
            add_string_body(n);
            put(CH_QUOTE);
          end
          6: begin
            put_text("//");
            repeat (n) begin
              c = any_byte();
              put((c == CH_LF || c == CH_CR) ? 8'h20 : c);
            end
            put(pick("\012\015"));
          end
          7: begin
            put_text("/*");
            repeat (n) put(pick("*/ab* "));
            put_text("*/");
          end
          8: put(CH_SLASH);
          9: put(CH_MINUS);
          10: put(pick(Unknowns));
          11: put(8'($urandom_range(128, 255)));
          default: put(any_byte());
        endcase
      end
      case ($urandom_range(0, 7))
        0: begin
          put(CH_QUOTE);
          add_string_body($urandom_range(0, 5));
        end
        1: begin
          put(CH_QUOTE);
          add_string_body($urandom_range(0, 5));
          put(CH_BACKSLASH);
        end
        2: put_text("/*x*");
        3: put_text("// x");
        4: put(CH_SLASH);
        5: put(CH_MINUS);
        6: put(pick(Letters));
        default: put(pick(Digits));
      endcase
    end
    put(CH_NUL);
  endtask

  // Waits are drawn per word; every fourth stretch of forty words runs without any.
  function automatic int draw_wait(int idx);
    return (idx % 160 < 40) ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // Sender: presents text bytes, updates the model on each accepted word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_ch.valid   <= 1'b0;
      text_ch.char_in <= '0;
      gap_left = 0;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        tokenize_byte(text_ch.char_in);
        bytes_taken++;
        gap_left = draw_wait(bytes_taken);
      end
      if (!(text_ch.valid && !text_ch.ready)) begin
        if (gap_left > 0 || text_bytes.size() == 0) begin
          if (gap_left > 0) gap_left--;
          text_ch.valid <= 1'b0;
        end else begin
          text_ch.valid   <= 1'b1;
          text_ch.char_in <= text_bytes.pop_front();
        end
      end
    end
  end

  function automatic void check_field(string field, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $display("%0t: token %0d %s: expected %0d, got %0d", $time, tokens_taken, field,
               want, got);
      mismatches++;
    end
  endfunction

  // Receiver: stalls at random and checks each token against the oldest expected one.
  always @(posedge clk_i or negedge rst_ni) begin
    token_t want;
    if (!rst_ni) begin
      tok_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (tok_ch.valid && tok_ch.ready) begin
        if (tokens_due.size() == 0) begin
          $display("%0t: token %0d: expected none, got kind %0d start %0d length %0d last %0b",
                   $time, tokens_taken, tok_ch.token_kind, tok_ch.token_start,
                   tok_ch.token_length, tok_ch.last_of_run);
          mismatches++;
        end else begin
          want = tokens_due.pop_front();
          check_field("kind", 12'(want.kind), 12'(tok_ch.token_kind));
          check_field("start", want.start, tok_ch.token_start);
          check_field("length", want.length, tok_ch.token_length);
          check_field("last", 12'(want.last), 12'(tok_ch.last_of_run));
        end
        tokens_taken++;
        stall_left = draw_wait(tokens_taken);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      tok_ch.ready <= (stall_left == 0);
    end
  end

  initial begin
    int base;
    rst_ni <= 1'b0;

    // Directed text: every punctuation mark and the end token; then an identifier, a number
    // with a minus, a lone minus before a slash, a lone slash, a byte of all ones, and an
    // open string ending on a backslash; then a line comment and an open block comment.
    put_text("(){}[]:;,*=");
    put(CH_NUL);
    put_text("Z_9-7.-/x");
    put(8'hFF);
    put(CH_QUOTE);
    put(CH_BACKSLASH);
    put(CH_NUL);
    put_text("//a\012/*");
    put(CH_NUL);

    base = text_bytes.size();
    while (text_bytes.size() - base < RandomBytes) add_stream();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(text_bytes.size() == 0 && !text_ch.valid && tokens_due.size() == 0) &&
           cycles < CycleLimit)
      @(posedge clk_i);

    if (cycles >= CycleLimit) begin
      $display("end of test: mismatches");
    end else begin
      // Give any stray token time to show up.
      repeat (DrainCycles) @(posedge clk_i);
      if (mismatches == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
    end
    $finish;
  end

endmodule
